FILE: rtl/core/dlle_pkg.sv
// shared types and codes for the ordered list engine
// used by dlle_ctrl, dlle_datapath and the top level; no dependencies
package dlle_pkg;

    localparam int OUT_W   = 5;
    localparam int MAX_RES = 16;

    typedef logic [2:0] t_mode;
    typedef logic [1:0] t_stat;

    localparam t_mode MODE_INS_FRONT = 3'd0;
    localparam t_mode MODE_INS_BACK  = 3'd1;
    localparam t_mode MODE_INS_AFTER = 3'd2;
    localparam t_mode MODE_DELETE    = 3'd3;
    localparam t_mode MODE_SEARCH    = 3'd4;
    localparam t_mode MODE_READ      = 3'd5;

    localparam t_stat STAT_OK        = 2'd0;
    localparam t_stat STAT_NOT_FOUND = 2'd1;
    localparam t_stat STAT_EMPTY     = 2'd2;
    localparam t_stat STAT_FULL      = 2'd3;

    typedef struct packed {
        logic  load;
        logic  init_up;
        logic  init_down;
        logic  walk_up;
        logic  walk_down;
        logic  del_write;
        logic  del_finish;
        logic  ins_write;
        logic  pos_zero;
        logic  pos_len;
        logic  capture_hit;
        logic  post;
        t_stat code;
        logic  use_pos;
        logic  use_rem;
        logic  use_elem;
        logic  last;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  empty;
        logic  full;
        logic  match;
        logic  up_done;
        logic  down_done;
        logic  del_none;
        logic  rd_last;
        logic  out_free;
    } t_sts;

endpackage

FILE: rtl/core/dlle_ctrl.sv
// request sequencer of the ordered list engine
// drives dlle_datapath through dlle_pkg::t_cmd and reads dlle_pkg::t_sts
module dlle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  dlle_pkg::t_sts i_sts,
    output dlle_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import dlle_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_DEL     = 3'd3;
    localparam logic [2:0] S_SHIFT   = 3'd4;
    localparam logic [2:0] S_RD      = 3'd5;
    localparam logic [2:0] S_RD_WAIT = 3'd6;
    localparam logic [2:0] S_POST    = 3'd7;

    logic [2:0] r_state, n_state;
    t_stat      r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= STAT_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.mode) inside
                    MODE_INS_FRONT, MODE_INS_BACK: begin
                        if (i_sts.full) begin
                            n_code  = STAT_FULL;
                            n_state = S_POST;
                        end else begin
                            o_cmd.pos_zero  = (i_sts.mode == MODE_INS_FRONT);
                            o_cmd.pos_len   = (i_sts.mode == MODE_INS_BACK);
                            o_cmd.init_down = 1'b1;
                            n_state         = S_SHIFT;
                        end
                    end
                    MODE_INS_AFTER, MODE_SEARCH, MODE_DELETE, MODE_READ: begin
                        if (i_sts.empty) begin
                            n_code  = STAT_EMPTY;
                            n_state = S_POST;
                        end else begin
                            o_cmd.init_up = 1'b1;
                            if (i_sts.mode == MODE_DELETE) begin
                                n_state = S_DEL;
                            end else if (i_sts.mode == MODE_READ) begin
                                n_state = S_RD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    end
                    default: begin
                        // unused codes give no result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.walk_up = 1'b1;
                if (i_sts.match) begin
                    o_cmd.capture_hit = 1'b1;
                    if (i_sts.mode == MODE_SEARCH) begin
                        n_code  = STAT_OK;
                        n_state = S_POST;
                    end else if (i_sts.full) begin
                        n_code  = STAT_FULL;
                        n_state = S_POST;
                    end else begin
                        o_cmd.init_down = 1'b1;
                        n_state         = S_SHIFT;
                    end
                end else if (i_sts.up_done) begin
                    n_code  = STAT_NOT_FOUND;
                    n_state = S_POST;
                end
            end
            S_DEL: begin
                o_cmd.walk_up   = 1'b1;
                o_cmd.del_write = 1'b1;
                if (i_sts.up_done) begin
                    o_cmd.del_finish = 1'b1;
                    n_code  = i_sts.del_none ? STAT_NOT_FOUND : STAT_OK;
                    n_state = S_POST;
                end
            end
            S_SHIFT: begin
                o_cmd.walk_down = 1'b1;
                if (i_sts.down_done) begin
                    o_cmd.ins_write = 1'b1;
                    n_code  = STAT_OK;
                    n_state = S_POST;
                end
            end
            S_RD: begin
                o_cmd.walk_up = 1'b1;
                n_state       = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.post     = 1'b1;
                    o_cmd.code     = STAT_OK;
                    o_cmd.use_elem = 1'b1;
                    o_cmd.last     = i_sts.rd_last;
                    n_state        = i_sts.rd_last ? S_IDLE : S_RD;
                end
            end
            S_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.post    = 1'b1;
                    o_cmd.code    = r_code;
                    o_cmd.use_pos = (i_sts.mode == MODE_SEARCH) && (r_code == STAT_OK);
                    o_cmd.use_rem = (i_sts.mode == MODE_DELETE) && (r_code != STAT_EMPTY);
                    o_cmd.last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/dlle_datapath.sv
// element store, walk pointers and result register of the ordered list engine
// depends on dlle_pkg for the command and status structs
module dlle_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dlle_pkg::t_cmd        i_cmd,
    output dlle_pkg::t_sts        o_sts,
    input  dlle_pkg::t_mode       i_mode,
    input  logic signed [31:0]    i_key,
    input  logic signed [31:0]    i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dlle_pkg::t_stat       o_status,
    output logic [4:0]            o_position,
    output logic [4:0]            o_removed,
    output logic signed [31:0]    o_element,
    output logic [4:0]            o_length,
    output logic                  o_last
);
    import dlle_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int EW = LW + OUT_W;

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    t_mode       r_mode;
    logic [31:0] r_key, r_value;
    logic [LW-1:0] r_len, r_idx, r_rd_idx, r_wptr, r_pos, r_rem;
    logic        r_rd_vld;

    logic        r_out_valid;
    t_stat       r_o_status;
    logic [4:0]  r_o_position, r_o_removed, r_o_length;
    logic [31:0] r_o_element;
    logic        r_o_last;

    logic          up_go, dn_go, w_re, del_wr, sh_wr, w_we;
    logic [LW-1:0] w_idx_m1, w_waddr;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_wdata;
    logic [EW-1:0] w_pos_x, w_rem_x, w_len_x, w_rd_nx;

    assign up_go    = i_cmd.walk_up && (r_idx < r_len);
    assign dn_go    = i_cmd.walk_down && (r_idx > r_pos);
    assign w_re     = up_go || dn_go;
    assign w_idx_m1 = r_idx - {{(LW-1){1'b0}}, 1'b1};
    assign w_raddr  = up_go ? r_idx[AW-1:0] : w_idx_m1[AW-1:0];

    // compaction keeps the words that differ from the key
    assign del_wr  = i_cmd.del_write && r_rd_vld && (r_rdata != r_key);
    // shifting copies each word one slot toward the back
    assign sh_wr   = i_cmd.walk_down && r_rd_vld;
    assign w_we    = i_cmd.ins_write || sh_wr || del_wr;
    assign w_waddr = i_cmd.ins_write ? r_pos : (sh_wr ? r_rd_idx : r_wptr);
    assign w_wdata = i_cmd.ins_write ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr[AW-1:0]] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_up || i_cmd.init_down) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.walk_up || i_cmd.walk_down) begin
                r_rd_vld <= w_re;
            end
            if (i_cmd.ins_write) begin
                r_len <= r_len + {{(LW-1){1'b0}}, 1'b1};
            end else if (i_cmd.del_finish) begin
                r_len <= r_wptr;
            end
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_pos_x = {{OUT_W{1'b0}}, r_pos};
    assign w_rem_x = {{OUT_W{1'b0}}, r_rem};
    assign w_len_x = {{OUT_W{1'b0}}, r_len};
    assign w_rd_nx = {{OUT_W{1'b0}}, r_rd_idx} + {{(EW-1){1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.init_up) begin
            r_idx  <= '0;
            r_wptr <= '0;
        end else if (i_cmd.init_down) begin
            r_idx <= r_len;
        end else if (up_go) begin
            r_idx <= r_idx + {{(LW-1){1'b0}}, 1'b1};
        end else if (dn_go) begin
            r_idx <= w_idx_m1;
        end
        if (w_re) begin
            r_rd_idx <= r_idx;
        end
        if (del_wr) begin
            r_wptr <= r_wptr + {{(LW-1){1'b0}}, 1'b1};
        end
        if (i_cmd.pos_zero) begin
            r_pos <= '0;
        end else if (i_cmd.pos_len) begin
            r_pos <= r_len;
        end else if (i_cmd.capture_hit) begin
            r_pos <= r_rd_idx + {{(LW-1){1'b0}}, 1'b1};
        end
        if (i_cmd.del_finish) begin
            r_rem <= r_len - r_wptr;
        end
        if (i_cmd.post) begin
            r_o_status   <= i_cmd.code;
            r_o_position <= i_cmd.use_pos ? w_pos_x[OUT_W-1:0] : '0;
            r_o_removed  <= i_cmd.use_rem ? w_rem_x[OUT_W-1:0] : '0;
            r_o_element  <= i_cmd.use_elem ? r_rdata : '0;
            r_o_length   <= w_len_x[OUT_W-1:0];
            r_o_last     <= i_cmd.last;
        end
    end

    assign o_sts.mode      = r_mode;
    assign o_sts.empty     = (r_len == '0);
    assign o_sts.full      = (r_len == LW'(DEPTH));
    assign o_sts.match     = r_rd_vld && (r_rdata == r_key);
    assign o_sts.up_done   = !r_rd_vld && (r_idx >= r_len);
    assign o_sts.down_done = !r_rd_vld && (r_idx == r_pos);
    assign o_sts.del_none  = (r_wptr == r_len);
    assign o_sts.rd_last   = (w_rd_nx == w_len_x) || (w_rd_nx == EW'(MAX_RES));
    assign o_sts.out_free  = !r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_position  = r_o_position;
    assign o_removed   = r_o_removed;
    assign o_element   = r_o_element;
    assign o_length    = r_o_length;
    assign o_last      = r_o_last;

endmodule

FILE: rtl/core/doubly_linked_list_engine_unit.sv
// ordered list engine: holds up to DEPTH signed words in order.
// input channel: i_in_valid / o_in_stall with i_mode, i_key, i_value; one beat
//   per request. modes: insert front, insert back, insert after key, delete
//   key, search, read out.
// output channel: o_out_valid / i_out_stall; every request gives one result
//   beat with o_last set, read out gives one beat per element (at most 16),
//   the final one with o_last. unused modes give no beat.
// one request is worked on at a time; o_in_stall is high from acceptance until
//   the last result beat is loaded into the output register.
// work per request: decode, then the mode's walk, then the result post; insert
//   front/back shifts the words from the insert position on one slot toward
//   the back, search scans the list on the single read port, insert after
//   adds the scan plus the shift, delete compacts the whole list, and read out
//   reads and posts each element in turn.
//   the memory has one read and one write port.
// reset clears the length to zero and empties the output register; the
//   element store is not cleared.
// a stall on the output holds the result register; the engine waits before
//   posting the next result and resumes when the beat is taken.
module doubly_linked_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dlle_pkg::t_mode       i_mode,
    input  logic signed [31:0]    i_key,
    input  logic signed [31:0]    i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dlle_pkg::t_stat       o_status,
    output logic [4:0]            o_position,
    output logic [4:0]            o_removed,
    output logic signed [31:0]    o_element,
    output logic [4:0]            o_length,
    output logic                  o_last
);
    import dlle_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dlle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (o_in_stall)
    );

    dlle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_removed   (o_removed),
        .o_element   (o_element),
        .o_length    (o_length),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // an accepted request keeps the engine busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("engine not busy after accepting a request");

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_OK) |-> (o_position == 5'd0 && o_element == 0))
        else $error("failed request carries position or element");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_FULL) |-> (o_length == 5'(DEPTH)))
        else $error("full status with list not at capacity");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_removed != 5'd0) |-> (o_status == STAT_OK))
        else $error("removed count with non-ok status");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// testbench for doubly_linked_list_engine_unit: directed and random list requests
// checked beat by beat against an in-bench list predictor; depends on dlle_pkg
module tb;
    import dlle_pkg::*;

    localparam int DEPTH         = 16;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int MAX_REPORTS   = 200;

    // mode codes the block ignores
    localparam t_mode MODE_SPARE_A = 3'd6;
    localparam t_mode MODE_SPARE_B = 3'd7;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        t_stat              status;
        logic [4:0]         position;
        logic [4:0]         removed;
        logic signed [31:0] element;
        logic [4:0]         length;
        logic               last;
    } t_list_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_mode              i_mode      = MODE_INS_FRONT;
    logic signed [31:0] i_key       = '0;
    logic signed [31:0] i_value     = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_stat              o_status;
    logic [4:0]         o_position;
    logic [4:0]         o_removed;
    logic signed [31:0] o_element;
    logic [4:0]         o_length;
    logic               o_last;

    logic signed [31:0] stored_words [DEPTH];
    int                 word_count  = 0;
    t_list_result       pending_results [$];
    int                 error_count = 0;
    int                 idle_pct    = 0;
    int                 stall_pct   = 0;

    doubly_linked_list_engine_unit #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_removed   (o_removed),
        .o_element   (o_element),
        .o_length    (o_length),
        .o_last      (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // updates the list copy for one accepted request and queues the beats it must give
    task automatic apply_list_request(input t_mode mode, input logic signed [31:0] key,
                                      input logic signed [31:0] value);
        int    hit;
        int    ins_pos;
        int    keep;
        int    n;
        int    pos_out;
        int    rem_out;
        t_stat code;
        hit     = -1;
        ins_pos = -1;
        pos_out = 0;
        rem_out = 0;
        code    = STAT_OK;
        for (int i = 0; i < word_count; i++) begin
            if (hit < 0 && stored_words[i] == key) hit = i;
        end
        case (mode)
            MODE_INS_FRONT, MODE_INS_BACK: begin
                if (word_count >= DEPTH) code = STAT_FULL;
                else ins_pos = (mode == MODE_INS_FRONT) ? 0 : word_count;
            end
            MODE_INS_AFTER: begin
                if (word_count == 0) code = STAT_EMPTY;
                else if (hit < 0) code = STAT_NOT_FOUND;
                else if (word_count >= DEPTH) code = STAT_FULL;
                else ins_pos = hit + 1;
            end
            MODE_DELETE: begin
                if (word_count == 0) begin
                    code = STAT_EMPTY;
                end else begin
                    keep = 0;
                    for (int i = 0; i < word_count; i++) begin
                        if (stored_words[i] != key) begin
                            stored_words[keep] = stored_words[i];
                            keep++;
                        end
                    end
                    rem_out    = word_count - keep;
                    word_count = keep;
                    if (rem_out == 0) code = STAT_NOT_FOUND;
                end
            end
            MODE_SEARCH: begin
                if (word_count == 0) code = STAT_EMPTY;
                else if (hit < 0) code = STAT_NOT_FOUND;
                else pos_out = hit + 1;
            end
            MODE_READ: begin
                if (word_count == 0) begin
                    code = STAT_EMPTY;
                end else begin
                    n = (word_count < MAX_RES) ? word_count : MAX_RES;
                    for (int i = 0; i < n; i++) begin
                        pending_results.push_back('{status: STAT_OK, position: 5'd0,
                            removed: 5'd0, element: stored_words[i],
                            length: 5'(word_count), last: (i == n - 1)});
                    end
                    return;
                end
            end
            default: return;
        endcase
        if (ins_pos >= 0) begin
            for (int i = word_count; i > ins_pos; i--) stored_words[i] = stored_words[i - 1];
            stored_words[ins_pos] = value;
            word_count++;
        end
        pending_results.push_back('{status: code, position: 5'(pos_out), removed: 5'(rem_out),
            element: 32'sd0, length: 5'(word_count), last: 1'b1});
    endtask

    task automatic send_request(input t_mode mode, input logic signed [31:0] key,
                                input logic signed [31:0] value);
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_key      <= key;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        apply_list_request(mode, key, value);
        // the beat is taken, so valid drops before anything else changes
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // sender holds off until every queued beat has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pool_word(input int idx);
        case (idx)
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5:       return 32'sd5;
            6:       return 32'sd42;
            default: return -32'sd42;
        endcase
    endfunction

    // small pool so duplicates and matches are common, full-width words now and then
    function automatic logic signed [31:0] pick_word();
        if ($urandom_range(99) < 75) return pool_word($urandom_range(7));
        return $urandom;
    endfunction

    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 50 && word_count > 0) return stored_words[$urandom_range(word_count - 1)];
        if (r < 85) return pool_word($urandom_range(7));
        return $urandom;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat: expected none, got status %0d length %0d",
                             $time, o_status, o_length);
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("position", want.position, o_position);
                check_field("removed", want.removed, o_removed);
                check_field("element", want.element, o_element);
                check_field("length", want.length, o_length);
                check_field("last", want.last, o_last);
            end
        end
    end

    task automatic test_empty_list();
        send_request(MODE_SEARCH, 32'sd0, 32'sd0);
        send_request(MODE_DELETE, WORD_MIN, 32'sd0);
        send_request(MODE_INS_AFTER, 32'sd0, 32'sd1);
        send_request(MODE_READ, 32'sd0, 32'sd0);
        send_request(MODE_SPARE_B, -32'sd1, -32'sd1);
    endtask

    task automatic test_basic_ops();
        send_request(MODE_INS_FRONT, 32'sd0, WORD_MIN);
        send_request(MODE_INS_BACK, 32'sd0, WORD_MAX);
        // insert after the tail element
        send_request(MODE_INS_AFTER, WORD_MAX, 32'sd0);
        send_request(MODE_INS_AFTER, WORD_MIN, 32'sd7);
        // duplicate key: the new word goes in once, after the first match
        send_request(MODE_INS_BACK, 32'sd0, 32'sd7);
        send_request(MODE_INS_AFTER, 32'sd7, 32'sd3);
        send_request(MODE_SEARCH, WORD_MAX, 32'sd0);
        send_request(MODE_SEARCH, 32'sd123, 32'sd0);
        send_request(MODE_DELETE, 32'sd123, 32'sd0);
        send_request(MODE_READ, 32'sd0, 32'sd0);
    endtask

    task automatic test_full_list();
        repeat (DEPTH - 6) send_request(MODE_INS_BACK, 32'sd0, 32'sd5);
        send_request(MODE_INS_FRONT, 32'sd0, 32'sd9);
        send_request(MODE_INS_AFTER, 32'sd5, 32'sd9);
        send_request(MODE_READ, 32'sd0, 32'sd0);
        send_request(MODE_DELETE, 32'sd5, 32'sd0);
    endtask

    task automatic test_random(input int idle, input int stall, input int count);
        int    sent;
        int    r;
        t_mode mode;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < count) begin
            // now and then empty the list one key at a time
            if (word_count > 0 && $urandom_range(39) == 0) begin
                while (word_count > 0) begin
                    send_request(MODE_DELETE, stored_words[0], $urandom);
                    sent++;
                end
            end
            r = $urandom_range(99);
            if (r < 20) mode = MODE_INS_FRONT;
            else if (r < 40) mode = MODE_INS_BACK;
            else if (r < 55) mode = MODE_INS_AFTER;
            else if (r < 67) mode = MODE_DELETE;
            else if (r < 80) mode = MODE_SEARCH;
            else if (r < 92) mode = MODE_READ;
            else mode = r[0] ? MODE_SPARE_A : MODE_SPARE_B;
            send_request(mode, pick_key(), pick_word());
            if (mode != MODE_SPARE_A && mode != MODE_SPARE_B) sent++;
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_basic_ops();
        test_full_list();
        drain_results();
        test_random(0, 0, 50);
        test_random(87, 0, 45);
        test_random(0, 87, 45);
        test_random(27, 27, 50);
        test_random(0, 0, 50);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
